// ===== rtl/qrs_pkg.sv =====
// Package for the quadratic root solver: payload types and fixed widths.
`default_nettype none
package qrs_pkg;

   // Width of every coefficient and root field
   localparam int COEF_WIDTH = 32;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] coef_a;
      logic signed [COEF_WIDTH-1:0] coef_b;
      logic signed [COEF_WIDTH-1:0] coef_c;
   } req_payload_type;

   typedef struct packed {
      logic                         found;
      logic                         is_linear;
      logic signed [COEF_WIDTH-1:0] root_near;
      logic signed [COEF_WIDTH-1:0] root_far;
      logic                         overflow;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ===== rtl/qrs_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage.
`default_nettype none
module qrs_sqrt_pipe #(
   parameter int ROOT_W = 33,
   parameter int SIDE_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_rad,
   input  wire logic [SIDE_W-1:0]     in_side,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [SIDE_W-1:0]          out_side
);

   localparam int RemW = ROOT_W + 2;

   logic                  valid_ff [0:ROOT_W-1];
   logic [RemW-1:0]       rem_ff   [0:ROOT_W-1];
   logic [ROOT_W-1:0]     root_ff  [0:ROOT_W-1];
   logic [2*ROOT_W-1:0]   rad_ff   [0:ROOT_W-1];
   logic [SIDE_W-1:0]     side_ff  [0:ROOT_W-1];

   // taps: index 0 is the pipe input, index k+1 the output of stage k
   logic                  valid_tap [0:ROOT_W];
   logic [RemW-1:0]       rem_tap   [0:ROOT_W];
   logic [ROOT_W-1:0]     root_tap  [0:ROOT_W];
   logic [2*ROOT_W-1:0]   rad_tap   [0:ROOT_W];
   logic [SIDE_W-1:0]     side_tap  [0:ROOT_W];

   assign valid_tap[0] = in_valid;
   assign rem_tap[0]   = '0;
   assign root_tap[0]  = '0;
   assign rad_tap[0]   = in_rad;
   assign side_tap[0]  = in_side;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [RemW+1:0]   rem_sh;
      logic [RemW+1:0]   trial;
      logic [RemW-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      // bring down two radicand bits and try the next root bit
      always_comb begin
         rem_sh = {rem_tap[k], rad_tap[k][2*ROOT_W-1 -: 2]};
         trial  = {2'b00, root_tap[k], 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = RemW'(rem_sh - trial);
            root_in = {root_tap[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RemW-1:0];
            root_in = {root_tap[k][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_tap[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_tap[k][2*ROOT_W-3:0], 2'b00};
            side_ff[k] <= side_tap[k];
         end
      end

      assign valid_tap[k+1] = valid_ff[k];
      assign rem_tap[k+1]   = rem_ff[k];
      assign root_tap[k+1]  = root_ff[k];
      assign rad_tap[k+1]   = rad_ff[k];
      assign side_tap[k+1]  = side_ff[k];
   end

   assign out_valid = valid_tap[ROOT_W];
   assign out_root  = root_tap[ROOT_W];
   assign out_side  = side_tap[ROOT_W];

endmodule
`default_nettype wire

// ===== rtl/qrs_div_pipe.sv =====
// Pipelined restoring unsigned divider, one quotient bit per register stage.
`default_nettype none
module qrs_div_pipe #(
   parameter int NUM_W  = 50,
   parameter int DEN_W  = 33,
   parameter int SIDE_W = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire logic [NUM_W-1:0]   in_num,
   input  wire logic [DEN_W-1:0]   in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic [NUM_W-1:0]        out_quot,
   output logic [SIDE_W-1:0]       out_side
);

   logic               valid_ff [0:NUM_W-1];
   logic [DEN_W-1:0]   rem_ff   [0:NUM_W-1];
   logic [NUM_W-1:0]   num_ff   [0:NUM_W-1];
   logic [NUM_W-1:0]   quot_ff  [0:NUM_W-1];
   logic [DEN_W-1:0]   den_ff   [0:NUM_W-1];
   logic [SIDE_W-1:0]  side_ff  [0:NUM_W-1];

   logic               valid_tap [0:NUM_W];
   logic [DEN_W-1:0]   rem_tap   [0:NUM_W];
   logic [NUM_W-1:0]   num_tap   [0:NUM_W];
   logic [NUM_W-1:0]   quot_tap  [0:NUM_W];
   logic [DEN_W-1:0]   den_tap   [0:NUM_W];
   logic [SIDE_W-1:0]  side_tap  [0:NUM_W];

   assign valid_tap[0] = in_valid;
   assign rem_tap[0]   = '0;
   assign num_tap[0]   = in_num;
   assign quot_tap[0]  = '0;
   assign den_tap[0]   = in_den;
   assign side_tap[0]  = in_side;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W-1:0] rem_in;
      logic             qbit;

      // shift in one dividend bit, subtract the divisor if it fits
      always_comb begin
         rem_sh = {rem_tap[k], num_tap[k][NUM_W-1]};
         qbit   = (rem_sh >= {1'b0, den_tap[k]});
         if (qbit) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_tap[k]});
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_tap[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= {num_tap[k][NUM_W-2:0], 1'b0};
            quot_ff[k] <= {quot_tap[k][NUM_W-2:0], qbit};
            den_ff[k]  <= den_tap[k];
            side_ff[k] <= side_tap[k];
         end
      end

      assign valid_tap[k+1] = valid_ff[k];
      assign rem_tap[k+1]   = rem_ff[k];
      assign num_tap[k+1]   = num_ff[k];
      assign quot_tap[k+1]  = quot_ff[k];
      assign den_tap[k+1]   = den_ff[k];
      assign side_tap[k+1]  = side_ff[k];
   end

   assign out_valid = valid_tap[NUM_W];
   assign out_quot  = quot_tap[NUM_W];
   assign out_side  = side_tap[NUM_W];

endmodule
`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
// Quadratic root solver: streams one a*t^2+b*t+c=0 coefficient triple per item.
//
// Input channel req_*: one item carries coef_a, coef_b, coef_c, signed fixed
// point with FRAC_BITS fraction bits. Result channel rsp_*: one item per input
// item, in order: found, is_linear, root_near, root_far, overflow.
// Throughput: one item per cycle, sustained, when the receiver does not stall.
// Each item passes the coefficient register, the product register, the square
// root pipe (W+1 stages, one root bit each), the divider input register, the
// two parallel divider pipes (W+2+FRAC_BITS stages, one quotient bit each) and
// the output register, W being the coefficient width (default format Q16.16).
// All stages advance together while the output register is empty or being
// taken; when rsp_stall holds a waiting result the whole pipe freezes and
// req_stall is raised, so nothing is lost or repeated.
// Reset (synchronous, active high) clears every valid bit; the first item
// can be offered in the cycle after reset falls.
// a=b=0 or a negative discriminant give found=0 with all other fields zero.
`default_nettype none
module quadratic_root_solver #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire qrs_pkg::req_payload_type   req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output qrs_pkg::rsp_payload_type        rsp_payload
);

   localparam int W      = qrs_pkg::COEF_WIDTH;
   localparam int RootW  = W + 1;              // square root width
   localparam int MagW   = W + 2;              // numerator magnitude width
   localparam int NumW   = MagW + FRAC_BITS;   // scaled dividend width
   localparam int DenW   = W + 1;              // divisor magnitude width
   localparam int SideW  = 4 + 3 * W;
   localparam logic [NumW-1:0] LimPos = {{(NumW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NumW-1:0] LimNeg = LimPos + NumW'(1);

   logic advance;

   // whole pipe moves unless a finished item is held by the receiver
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ---- stage 1: capture coefficients
   logic                s1_valid_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff, s1_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_a_ff <= req_payload.coef_a;
         s1_b_ff <= req_payload.coef_b;
         s1_c_ff <= req_payload.coef_c;
      end
   end

   // ---- stage 2: magnitudes and products
   logic [W-1:0] mag_a, mag_b, mag_c;

   always_comb begin
      mag_a = s1_a_ff[W-1] ? W'(-s1_a_ff) : W'(s1_a_ff);
      mag_b = s1_b_ff[W-1] ? W'(-s1_b_ff) : W'(s1_b_ff);
      mag_c = s1_c_ff[W-1] ? W'(-s1_c_ff) : W'(s1_c_ff);
   end

   logic                s2_valid_ff;
   logic [2*W-1:0]      s2_bb_ff, s2_ac_ff;
   logic [W-1:0]        s2_ma_ff, s2_mb_ff, s2_mc_ff;
   logic signed [W-1:0] s2_b_ff;
   logic                s2_sa_ff, s2_sc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_bb_ff <= mag_b * mag_b;
         s2_ac_ff <= mag_a * mag_c;
         s2_ma_ff <= mag_a;
         s2_mb_ff <= mag_b;
         s2_mc_ff <= mag_c;
         s2_b_ff  <= s1_b_ff;
         s2_sa_ff <= s1_a_ff[W-1];
         s2_sc_ff <= s1_c_ff[W-1];
      end
   end

   // ---- discriminant and case decision, straight into the square root
   logic [2*W+1:0] bb_x, ac4, disc;
   logic           a_zero, b_zero, no_real, lin, found, neg_lin;
   logic [SideW-1:0] sq_side_in;

   always_comb begin
      bb_x    = {2'b00, s2_bb_ff};
      ac4     = {s2_ac_ff, 2'b00};
      no_real = 1'b0;
      if (s2_sa_ff != s2_sc_ff) begin
         disc = bb_x + ac4;
      end else begin
         no_real = (bb_x < ac4);
         disc    = bb_x - ac4;
      end
      a_zero  = (s2_ma_ff == '0);
      b_zero  = (s2_mb_ff == '0);
      lin     = a_zero && !b_zero;
      found   = lin || (!a_zero && !no_real);
      // sign of -c/b: -c is negative when c is positive
      neg_lin = (!s2_sc_ff && (s2_mc_ff != '0)) != s2_b_ff[W-1];
      if (!found || lin) begin
         disc = '0;
      end
      sq_side_in = {lin, found, s2_sa_ff, neg_lin, s2_ma_ff, s2_b_ff, s2_mc_ff};
   end

   logic             sq_valid;
   logic [RootW-1:0] sq_root;
   logic [SideW-1:0] sq_side;

   qrs_sqrt_pipe #(
      .ROOT_W (RootW),
      .SIDE_W (SideW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s2_valid_ff),
      .in_rad    (disc),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---- prepare numerators and divisor for the two dividers
   logic                q_lin, q_found, q_sa, q_neg_lin;
   logic [W-1:0]        q_ma, q_mc;
   logic signed [W-1:0] q_b;
   logic signed [W+2:0] b_x, nb, near_n, far_n, mb_x;
   logic [MagW-1:0]     mag_near, mag_far;
   logic [DenW-1:0]     den;
   logic                neg_near, neg_far;

   always_comb begin
      {q_lin, q_found, q_sa, q_neg_lin, q_ma, q_b, q_mc} = sq_side;
      b_x    = {{3{q_b[W-1]}}, q_b};
      nb     = -b_x;
      near_n = nb - $signed({2'b00, sq_root});
      far_n  = nb + $signed({2'b00, sq_root});
      mb_x   = b_x[W+2] ? -b_x : b_x;
      if (q_lin) begin
         mag_near = {2'b00, q_mc};
         mag_far  = {2'b00, q_mc};
         den      = mb_x[DenW-1:0];
         neg_near = q_neg_lin;
         neg_far  = q_neg_lin;
      end else begin
         mag_near = near_n[W+2] ? MagW'(-near_n) : MagW'(near_n);
         mag_far  = far_n[W+2]  ? MagW'(-far_n)  : MagW'(far_n);
         den      = {q_ma, 1'b0};
         neg_near = near_n[W+2] != q_sa;
         neg_far  = far_n[W+2] != q_sa;
      end
   end

   logic            p_valid_ff;
   logic [NumW-1:0] p_num_near_ff, p_num_far_ff;
   logic [DenW-1:0] p_den_ff;
   logic            p_neg_near_ff, p_neg_far_ff, p_lin_ff, p_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_num_near_ff <= {mag_near, {FRAC_BITS{1'b0}}};
         p_num_far_ff  <= {mag_far, {FRAC_BITS{1'b0}}};
         p_den_ff      <= den;
         p_neg_near_ff <= neg_near;
         p_neg_far_ff  <= neg_far;
         p_lin_ff      <= q_lin;
         p_found_ff    <= q_found;
      end
   end

   // ---- dividers
   logic            dn_valid, df_valid;
   logic [NumW-1:0] dn_quot, df_quot;
   logic [2:0]      dn_side;
   logic            df_side;

   qrs_div_pipe #(
      .NUM_W  (NumW),
      .DEN_W  (DenW),
      .SIDE_W (3)
   ) u_div_near (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (p_valid_ff),
      .in_num    (p_num_near_ff),
      .in_den    (p_den_ff),
      .in_side   ({p_found_ff, p_lin_ff, p_neg_near_ff}),
      .out_valid (dn_valid),
      .out_quot  (dn_quot),
      .out_side  (dn_side)
   );

   qrs_div_pipe #(
      .NUM_W  (NumW),
      .DEN_W  (DenW),
      .SIDE_W (1)
   ) u_div_far (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (p_valid_ff),
      .in_num    (p_num_far_ff),
      .in_den    (p_den_ff),
      .in_side   (p_neg_far_ff),
      .out_valid (df_valid),
      .out_quot  (df_quot),
      .out_side  (df_side)
   );

   // ---- saturation and sign into the output register
   logic [NumW-1:0] lim_near, lim_far, m_near, m_far;
   logic            ov_near, ov_far;
   qrs_pkg::rsp_payload_type rsp_in;

   always_comb begin
      lim_near = dn_side[0] ? LimNeg : LimPos;
      lim_far  = df_side ? LimNeg : LimPos;
      ov_near  = dn_quot > lim_near;
      ov_far   = df_quot > lim_far;
      m_near   = ov_near ? lim_near : dn_quot;
      m_far    = ov_far ? lim_far : df_quot;
      rsp_in   = '0;
      if (dn_side[2]) begin
         rsp_in.found     = 1'b1;
         rsp_in.is_linear = dn_side[1];
         rsp_in.root_near = dn_side[0] ? W'(-m_near) : W'(m_near);
         rsp_in.root_far  = df_side ? W'(-m_far) : W'(m_far);
         rsp_in.overflow  = ov_near || ov_far;
      end
   end

   logic                     out_valid_ff;
   qrs_pkg::rsp_payload_type out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dn_valid && df_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule
`default_nettype wire
